FILE: rtl/core/slpd_pkg.sv
// ----------------------------------------------------------------------------
// slpd_pkg
// Shared types and constants for the status LED pattern driver: opcodes,
// register indexes, status codes and the blink time table.
// ----------------------------------------------------------------------------
package slpd_pkg;

  // led and field widths
  localparam int LED_W      = 4;
  localparam int STATUS_W   = 5;
  localparam int TICKS_W    = 12;
  localparam int LED_CNT_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_STATUS = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL = 1'd1;

  // led counts that do something
  localparam logic [LED_CNT_W-1:0] LEDS_BLINK = 3'd1;
  localparam logic [LED_CNT_W-1:0] LEDS_FULL  = 3'd4;

  // status codes
  localparam logic signed [STATUS_W-1:0] STATUS_SCAN = -5'sd1;
  localparam logic signed [STATUS_W-1:0] STATUS_OFF  = 5'sd0;
  localparam logic signed [STATUS_W-1:0] STATUS_SLOW = 5'sd1;
  localparam logic signed [STATUS_W-1:0] STATUS_MID  = 5'sd4;
  localparam logic signed [STATUS_W-1:0] STATUS_ON   = 5'sd15;

  // timing constants in ticks
  localparam logic [TICKS_W-1:0] ELAPSED_MAX       = 12'd4095;
  localparam logic [TICKS_W-1:0] END_HOLD_TICKS    = 12'd150;
  localparam logic [TICKS_W-1:0] SCAN_INTERVAL_RST = 12'd100;
  localparam logic [TICKS_W-1:0] TIME_SCAN         = 12'd2000;
  localparam logic [TICKS_W-1:0] TIME_SLOW         = 12'd100;
  localparam logic [TICKS_W-1:0] TIME_MID          = 12'd500;

  // first led is the top bit of the level vector
  localparam logic [LED_W-1:0] FIRST_LED = 4'b1000;

  // threshold with a flag for a level that never changes
  typedef struct packed {
    logic               never;
    logic [TICKS_W-1:0] ticks;
  } thresh_t;

  // on or off time of a status in blink mode
  function automatic thresh_t blink_time(logic signed [STATUS_W-1:0] status,
                                         logic lit);
    thresh_t t;
    t.never = 1'b0;
    t.ticks = '0;
    unique case (status)
      STATUS_SCAN: t.ticks = TIME_SCAN;
      STATUS_OFF:  t.never = !lit;
      STATUS_SLOW: t.ticks = TIME_SLOW;
      STATUS_MID:  t.ticks = TIME_MID;
      STATUS_ON:   t.never = lit;
      default:     t.ticks = '0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/status_led_pattern_driver_unit.sv
// ----------------------------------------------------------------------------
// status_led_pattern_driver_unit
// Drives up to four status LEDs from a status code, advanced by millisecond
// tick items: blink with one LED, scanner or binary code with four LEDs.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  in        in_valid/in_ready, opcode,       sink
//            status_code
//  out       out_valid/out_ready, led_levels  source
//  cfg       cfg_we, cfg_index, cfg_data      sink, write only
//
//  one item per cycle: each item is decoded and applied in the cycle it is
//  accepted, and the led state register doubles as the result register.
//  a new item is taken while the last result waits, as long as out_ready
//  takes that result in the same cycle; otherwise input stalls on a full
//  result register. reset clears all state and sets the scan interval to 100.
// ----------------------------------------------------------------------------
module status_led_pattern_driver_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  opcode,
  input  logic signed [slpd_pkg::STATUS_W-1:0]  status_code,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [slpd_pkg::LED_W-1:0]     led_levels,
  input  logic                                  cfg_we,
  input  logic        [slpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [slpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import slpd_pkg::*;

  // configuration registers
  logic [LED_CNT_W-1:0] led_count;
  logic [TICKS_W-1:0]   scan_interval_ms;

  // state
  logic signed [STATUS_W-1:0] current_status;
  logic [LED_W-1:0]           lit_levels;
  logic [TICKS_W-1:0]         elapsed_ticks;
  logic [1:0]                 scan_position;
  logic                       scan_moving_down;
  logic                       end_hold_pending;

  logic signed [STATUS_W-1:0] current_status_next;
  logic [LED_W-1:0]           lit_levels_next;
  logic [TICKS_W-1:0]         elapsed_ticks_next;
  logic [1:0]                 scan_position_next;
  logic                       scan_moving_down_next;
  logic                       end_hold_pending_next;

  logic                       in_accept;
  logic [TICKS_W-1:0]         elapsed_inc;
  thresh_t                    thresh;
  logic                       fire;
  logic [1:0]                 pos_step;

  // handshake
  assign in_ready   = !out_valid || out_ready;
  assign in_accept  = in_valid && in_ready;
  assign led_levels = lit_levels;

  // saturating tick count and threshold
  always_comb begin
    elapsed_inc = (elapsed_ticks == ELAPSED_MAX) ? elapsed_ticks
                                                 : elapsed_ticks + 12'd1;
    if (led_count == LEDS_BLINK) begin
      thresh = blink_time(current_status, lit_levels[LED_W-1]);
    end else begin
      thresh.never = 1'b0;
      thresh.ticks = scan_interval_ms;
    end
    if (end_hold_pending && !thresh.never && thresh.ticks < END_HOLD_TICKS) begin
      thresh.ticks = END_HOLD_TICKS;
    end
    fire = !thresh.never && (elapsed_inc >= thresh.ticks);
    pos_step = scan_moving_down ? scan_position - 2'd1 : scan_position + 2'd1;
  end

  // next state for one item
  always_comb begin
    current_status_next   = current_status;
    lit_levels_next       = lit_levels;
    elapsed_ticks_next    = elapsed_ticks;
    scan_position_next    = scan_position;
    scan_moving_down_next = scan_moving_down;
    end_hold_pending_next = end_hold_pending;
    if (opcode == OP_STATUS) begin
      // codes below the scanner code are dropped
      if (led_count != '0 && (!status_code[STATUS_W-1] || status_code == STATUS_SCAN)) begin
        current_status_next = status_code;
      end
    end else begin
      elapsed_ticks_next = elapsed_inc;
      if (fire) begin
        elapsed_ticks_next    = '0;
        end_hold_pending_next = 1'b0;
        if (led_count == LEDS_BLINK) begin
          lit_levels_next = lit_levels ^ FIRST_LED;
        end else if (led_count == LEDS_FULL) begin
          if (current_status == STATUS_SCAN) begin
            lit_levels_next    = FIRST_LED >> scan_position;
            scan_position_next = pos_step;
            // turn around at either end and hold there a while
            if (pos_step == 2'd3 || pos_step == 2'd0) begin
              scan_moving_down_next = !scan_moving_down;
              end_hold_pending_next = 1'b1;
            end
          end else begin
            lit_levels_next = current_status[LED_W-1:0];
          end
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count        <= '0;
      scan_interval_ms <= SCAN_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LED_COUNT:     led_count        <= cfg_data[LED_CNT_W-1:0];
        REG_SCAN_INTERVAL: scan_interval_ms <= cfg_data[TICKS_W-1:0];
        default:           led_count        <= led_count;
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      current_status   <= '0;
      lit_levels       <= '0;
      elapsed_ticks    <= '0;
      scan_position    <= '0;
      scan_moving_down <= 1'b0;
      end_hold_pending <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (in_accept) begin
        current_status   <= current_status_next;
        lit_levels       <= lit_levels_next;
        elapsed_ticks    <= elapsed_ticks_next;
        scan_position    <= scan_position_next;
        scan_moving_down <= scan_moving_down_next;
        end_hold_pending <= end_hold_pending_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
